/* sv/cfr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package cfr_pkg;

  // Frame opening bytes
  localparam logic [7:0] OPEN_STATUS  = 8'hA0;
  localparam logic [7:0] OPEN_SETCMD  = 8'hA1;
  localparam logic [7:0] OPEN_VERSION = 8'hA2;
  localparam logic [7:0] OPEN_DATE    = 8'hA3;
  localparam logic [7:0] OPEN_NAME    = 8'hA4;

  // Reply lead bytes
  localparam logic [7:0] RESP_STATUS  = 8'hC0;
  localparam logic [7:0] RESP_SETCMD  = 8'hC1;
  localparam logic [7:0] RESP_VERSION = 8'hC2;

  // Configuration register indexes
  localparam logic CFG_VERSION_MAJOR = 1'b0;
  localparam logic CFG_VERSION_MINOR = 1'b1;

  localparam logic [7:0] VERSION_RESET = 8'h01;

  // Reply queue
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = 1;
  localparam int unsigned QCNT_W = 2;

  // Index of the last reply byte, which is the checksum
  localparam logic [1:0] REPLY_LAST_IDX = 2'd3;

  typedef enum logic {
    FR_IDLE,
    FR_BODY
  } front_state_e;

  // One queued reply: three payload bytes plus the command register value
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] cmd;
  } reply_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

`default_nettype wire

/* sv/cfr_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module cfr_front
  import cfr_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] rx_byte_i,
  input  wire logic [5:0] monitor_flags_i,
  input  wire logic       err_pin_i,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_idx_i,
  input  wire logic [7:0] cfg_data_i,
  output logic            push_o,
  output reply_t          reply_o
);

  front_state_e state_q, state_d;
  logic [1:0] bytes_left_q, bytes_left_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] opener_q, opener_d;
  logic [7:0] arg_q, arg_d;
  logic [7:0] command_q, command_d;
  logic       link_ok_q, link_ok_d;
  logic       error_seen_q, error_seen_d;
  logic [7:0] vers_hi_q, vers_lo_q;

  logic is_open;
  logic frame_end;
  logic link_new;

  assign is_open = (rx_byte_i >= OPEN_STATUS) && (rx_byte_i <= OPEN_NAME);
  assign frame_end = (state_q == FR_BODY) && (bytes_left_q == 2'd1);
  assign link_new = (~sum_q == rx_byte_i);

  always_comb begin
    state_d = state_q;
    if (accept_i) begin
      unique case (state_q)
        FR_IDLE: if (is_open) state_d = FR_BODY;
        FR_BODY: if (frame_end) state_d = FR_IDLE;
        default: state_d = FR_IDLE;
      endcase
    end
  end

  always_comb begin
    bytes_left_d = bytes_left_q;
    sum_d        = sum_q;
    opener_d     = opener_q;
    arg_d        = arg_q;
    command_d    = command_q;
    link_ok_d    = link_ok_q;
    error_seen_d = error_seen_q;
    push_o       = 1'b0;
    reply_o      = '0;
    if (accept_i) begin
      unique case (state_q)
        FR_IDLE: begin
          if (is_open) begin
            opener_d     = rx_byte_i;
            sum_d        = rx_byte_i;
            bytes_left_d = (rx_byte_i == OPEN_SETCMD) ? 2'd2 : 2'd1;
          end
        end
        FR_BODY: begin
          bytes_left_d = bytes_left_q - 2'd1;
          if (!frame_end) begin
            // only the set-command frame has a body byte
            arg_d = rx_byte_i;
            sum_d = sum_q + rx_byte_i;
          end else begin
            link_ok_d = link_new;
            sum_d     = '0;
            priority case (opener_q)
              OPEN_STATUS: begin
                push_o  = 1'b1;
                reply_o = '{b0: RESP_STATUS, b1: command_q,
                            b2: {error_seen_q, link_new, monitor_flags_i},
                            cmd: command_q};
              end
              OPEN_SETCMD: begin
                command_d    = arg_q;
                error_seen_d = err_pin_i;
                push_o       = 1'b1;
                reply_o = '{b0: RESP_SETCMD, b1: arg_q,
                            b2: {err_pin_i, link_new, monitor_flags_i},
                            cmd: arg_q};
              end
              OPEN_VERSION: begin
                push_o  = 1'b1;
                reply_o = '{b0: RESP_VERSION, b1: vers_hi_q,
                            b2: vers_lo_q, cmd: command_q};
              end
              default: push_o = 1'b0; // date and name: checked, not answered
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= FR_IDLE;
      bytes_left_q <= '0;
      sum_q        <= '0;
      command_q    <= '0;
      link_ok_q    <= 1'b0;
      error_seen_q <= 1'b0;
      vers_hi_q    <= VERSION_RESET;
      vers_lo_q    <= VERSION_RESET;
    end else begin
      state_q      <= state_d;
      bytes_left_q <= bytes_left_d;
      sum_q        <= sum_d;
      command_q    <= command_d;
      link_ok_q    <= link_ok_d;
      error_seen_q <= error_seen_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_VERSION_MAJOR: vers_hi_q <= cfg_data_i;
          CFG_VERSION_MINOR: vers_lo_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    opener_q <= opener_d;
    arg_q    <= arg_d;
  end

endmodule

`default_nettype wire

/* sv/cfr_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module cfr_queue
  import cfr_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  reply_t       push_data_i,
  input  wire logic    pop_i,
  output reply_t       pop_data_o,
  output queue_status_t status_o
);

  reply_t mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;

  assign status_o.full  = (count_q == QCNT_W'(QDEPTH));
  assign status_o.empty = (count_q == '0);
  assign pop_data_o     = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

`default_nettype wire

/* sv/cfr_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module cfr_back
  import cfr_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  queue_status_t   q_status_i,
  input  reply_t          q_data_i,
  output logic            pop_o,
  output logic            m_valid_o,
  input  wire logic       m_ready_i,
  output logic [7:0]      tx_byte_o,
  output logic            last_byte_o,
  output logic [7:0]      command_bits_o
);

  logic       busy_q, busy_d;
  logic [1:0] idx_q, idx_d;
  reply_t     cur_q;
  logic [7:0] chk_q;
  logic       done;

  assign done  = busy_q && m_ready_i && (idx_q == REPLY_LAST_IDX);
  assign pop_o = (!busy_q || done) && !q_status_i.empty;

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (pop_o) begin
      busy_d = 1'b1;
      idx_d  = '0;
    end else if (done) begin
      busy_d = 1'b0;
      idx_d  = '0;
    end else if (busy_q && m_ready_i) begin
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= q_data_i;
      chk_q <= ~(q_data_i.b0 + q_data_i.b1 + q_data_i.b2);
    end
  end

  always_comb begin
    unique case (idx_q)
      2'd0:    tx_byte_o = cur_q.b0;
      2'd1:    tx_byte_o = cur_q.b1;
      2'd2:    tx_byte_o = cur_q.b2;
      default: tx_byte_o = chk_q;
    endcase
  end

  assign m_valid_o      = busy_q;
  assign last_byte_o    = (idx_q == REPLY_LAST_IDX);
  assign command_bits_o = cur_q.cmd;

  a_idle_idx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> idx_q == '0)
    else $error("byte index moved while no reply is held");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !m_ready_i |=> busy_q && $stable(idx_q))
    else $error("reply position changed during a stall");

  a_drain_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done && q_status_i.empty |=> !busy_q)
    else $error("back end stayed busy with nothing queued");

  a_no_pop_midreply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !done |-> !pop_o)
    else $error("queue popped in the middle of a reply");

endmodule

`default_nettype wire

/* sv/command_frame_responder.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tdata: rx_byte, monitor_flags, err_pin
// m_axis    out  m_axis_tvalid/m_axis_tready    tdata: tx_byte, command_bits; tlast
// cfg       in   cfg_we_i (no back-pressure)    cfg_idx_i, cfg_data_i
//
// The front end takes one byte per cycle while the reply queue has room.
// A completed frame queues a reply; the back end sends it as four items,
// one per cycle while m_axis_tready is high; a frame is at least two input bytes.
// The back end's one-byte-per-cycle serializer sets the sustained rate.
// Reset clears parser, status, command and queue state; versions reset to 1.
// Output stalls fill the two-entry queue, then hold s_axis_tready low.
module command_frame_responder
  import cfr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // [7:0] rx_byte, [13:8] monitor_flags, [14] err_pin
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,  // [7:0] tx_byte, [15:8] command_bits
  output logic             m_axis_tlast,  // last_byte: checksum item
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [7:0]  cfg_data_i
);

  logic          accept;
  logic          push;
  reply_t        push_data;
  logic          pop;
  reply_t        pop_data;
  queue_status_t q_status;
  logic [7:0]    tx_byte;
  logic [7:0]    command_bits;

  // a byte never pushes more than one reply, so room for one is enough
  assign s_axis_tready = !q_status.full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  cfr_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .rx_byte_i       (s_axis_tdata[7:0]),
    .monitor_flags_i (s_axis_tdata[13:8]),
    .err_pin_i       (s_axis_tdata[14]),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .push_o          (push),
    .reply_o         (push_data)
  );

  cfr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .status_o    (q_status)
  );

  cfr_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_status_i     (q_status),
    .q_data_i       (pop_data),
    .pop_o          (pop),
    .m_valid_o      (m_axis_tvalid),
    .m_ready_i      (m_axis_tready),
    .tx_byte_o      (tx_byte),
    .last_byte_o    (m_axis_tlast),
    .command_bits_o (command_bits)
  );

  assign m_axis_tdata = {command_bits, tx_byte};

endmodule

`default_nettype wire
